// File: src/hslrgb_pkg.sv
`default_nettype none
package hslrgb_pkg;

  localparam int unsigned HueW    = 15;
  localparam int unsigned ChanW   = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned SectorW = 3;
  localparam int unsigned TW      = 12;
  localparam int unsigned CnW     = 16;
  localparam int unsigned ProdW   = 28;
  localparam int unsigned NumW    = 29;
  localparam int unsigned QW      = 9;
  localparam int unsigned DivW    = 21;
  localparam int unsigned RecipW  = 12;

  localparam int unsigned NumSectors  = 6;
  localparam int unsigned SectorUnits = 3840;

  localparam logic [HueW-1:0]   HueFull    = 15'd23040;
  localparam logic [TW-1:0]     SectorSpan = 12'd3840;
  localparam logic [DivW-1:0]   OutDiv     = 21'd1958400;
  // floor(2^32 / OutDiv); the estimate it gives is at most one below the quotient.
  localparam logic [RecipW-1:0] OutRecip   = 12'd2193;
  localparam int unsigned       RecipShift = 32;

  localparam logic [ChanW-1:0] SatReset   = 8'd204;
  localparam logic [ChanW-1:0] LightReset = 8'd153;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSaturation = 2'd0,
    CfgLightness  = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic               valid;
    logic [SectorW-1:0] sector;
    logic [CnW-1:0]     cn;
    logic [ProdW-1:0]   prod;
    logic [ChanW-1:0]   light;
    logic [ChanW-1:0]   alpha;
  } front_t;

endpackage
`default_nettype wire

// File: src/hslrgb_front.sv
`default_nettype none
module hslrgb_front (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  input  wire logic [hslrgb_pkg::HueW-1:0]       hue_i,
  input  wire logic [hslrgb_pkg::ChanW-1:0]      alpha_i,
  input  wire logic [hslrgb_pkg::ChanW-1:0]      sat_i,
  input  wire logic [hslrgb_pkg::ChanW-1:0]      light_i,
  output hslrgb_pkg::front_t                     front_o
);

  // Stage 1: hue wrap and chroma width 255 - |2L - 255|.
  logic                             v1_q;
  logic [hslrgb_pkg::HueW-1:0]      h1_d, h1_q;
  logic [hslrgb_pkg::ChanW-1:0]     w1_d, w1_q;
  logic [hslrgb_pkg::ChanW:0]       two_l;
  logic [hslrgb_pkg::ChanW-1:0]     a1_q, s1_q, l1_q;

  // Stage 2: sector, offset inside it, chroma numerator.
  logic                             v2_q;
  logic [hslrgb_pkg::SectorW-1:0]   sec2_d, sec2_q;
  logic [hslrgb_pkg::HueW-1:0]      base2, f2_full;
  logic [hslrgb_pkg::TW-1:0]        f2, t2_d, t2_q;
  logic [hslrgb_pkg::CnW-1:0]       cn2_d, cn2_q;
  logic [hslrgb_pkg::ChanW-1:0]     a2_q, l2_q;

  // Stage 3: chroma times offset.
  logic                             v3_q;
  logic [hslrgb_pkg::SectorW-1:0]   sec3_q;
  logic [hslrgb_pkg::CnW-1:0]       cn3_q;
  logic [hslrgb_pkg::ProdW-1:0]     p3_d, p3_q;
  logic [hslrgb_pkg::ChanW-1:0]     a3_q, l3_q;

  assign h1_d  = (hue_i >= hslrgb_pkg::HueFull) ? hue_i - hslrgb_pkg::HueFull : hue_i;
  assign two_l = {light_i, 1'b0};
  always_comb begin
    if (light_i[hslrgb_pkg::ChanW-1]) begin
      w1_d = 8'(9'd510 - two_l);
    end else begin
      w1_d = two_l[hslrgb_pkg::ChanW-1:0];
    end
  end

  always_comb begin
    sec2_d = '0;
    base2  = '0;
    for (int k = 1; k < hslrgb_pkg::NumSectors; k++) begin
      if (h1_q >= 15'(k * hslrgb_pkg::SectorUnits)) begin
        sec2_d = 3'(k);
        base2  = 15'(k * hslrgb_pkg::SectorUnits);
      end
    end
  end

  assign f2_full = h1_q - base2;
  assign f2      = f2_full[hslrgb_pkg::TW-1:0];
  // Odd sectors run the secondary component downward.
  assign t2_d    = sec2_d[0] ? hslrgb_pkg::SectorSpan - f2 : f2;
  assign cn2_d   = {8'd0, w1_q} * {8'd0, s1_q};
  assign p3_d    = {12'd0, cn2_q} * {16'd0, t2_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    h1_q   <= h1_d;
    w1_q   <= w1_d;
    a1_q   <= alpha_i;
    s1_q   <= sat_i;
    l1_q   <= light_i;
    sec2_q <= sec2_d;
    t2_q   <= t2_d;
    cn2_q  <= cn2_d;
    a2_q   <= a1_q;
    l2_q   <= l1_q;
    sec3_q <= sec2_q;
    cn3_q  <= cn2_q;
    p3_q   <= p3_d;
    a3_q   <= a2_q;
    l3_q   <= l2_q;
  end

  always_comb begin
    front_o.valid  = v3_q;
    front_o.sector = sec3_q;
    front_o.cn     = cn3_q;
    front_o.prod   = p3_q;
    front_o.light  = l3_q;
    front_o.alpha  = a3_q;
  end

endmodule
`default_nettype wire

// File: src/hslrgb_mix.sv
`default_nettype none
module hslrgb_mix (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire hslrgb_pkg::front_t            front_i,
  output logic                               valid_o,
  output logic [hslrgb_pkg::ChanW-1:0]       alpha_o,
  output logic [hslrgb_pkg::NumW-1:0]        num_r_o,
  output logic [hslrgb_pkg::NumW-1:0]        num_g_o,
  output logic [hslrgb_pkg::NumW-1:0]        num_b_o
);

  typedef enum logic [1:0] {
    SelZero,
    SelChroma,
    SelSecond
  } chan_sel_e;

  logic [hslrgb_pkg::NumW-1:0] lterm, cterm, cadd, xadd;
  logic [hslrgb_pkg::NumW+1:0] base, sum_z, sum_c, sum_x;
  logic [hslrgb_pkg::NumW-1:0] num_z, num_c, num_x;
  chan_sel_e                   sel_r, sel_g, sel_b;
  logic                        valid_q;
  logic [hslrgb_pkg::ChanW-1:0] alpha_q;
  logic [hslrgb_pkg::NumW-1:0] num_r_d, num_g_d, num_b_d, num_r_q, num_g_q, num_b_q;

  function automatic logic [hslrgb_pkg::NumW-1:0] clip(input logic [hslrgb_pkg::NumW+1:0] v);
    logic [hslrgb_pkg::NumW-1:0] r;
    if (v[hslrgb_pkg::NumW+1]) begin
      r = '0;
    end else if (v[hslrgb_pkg::NumW]) begin
      r = '1;
    end else begin
      r = v[hslrgb_pkg::NumW-1:0];
    end
    return r;
  endfunction

  function automatic logic [hslrgb_pkg::NumW-1:0] pick(input chan_sel_e s,
      input logic [hslrgb_pkg::NumW-1:0] z, input logic [hslrgb_pkg::NumW-1:0] c,
      input logic [hslrgb_pkg::NumW-1:0] x);
    logic [hslrgb_pkg::NumW-1:0] r;
    case (s)
      SelChroma: r = c;
      SelSecond: r = x;
      default:   r = z;
    endcase
    return r;
  endfunction

  // Every channel is scaled so that one output step is OutDiv.
  assign lterm = {21'd0, front_i.light} * {8'd0, hslrgb_pkg::OutDiv};
  assign cterm = {13'd0, front_i.cn} * {17'd0, hslrgb_pkg::SectorSpan};
  assign cadd  = {cterm[hslrgb_pkg::NumW-2:0], 1'b0};
  assign xadd  = {front_i.prod, 1'b0};
  assign base  = {2'b00, lterm} - {2'b00, cterm};
  assign sum_z = base;
  assign sum_c = base + {2'b00, cadd};
  assign sum_x = base + {2'b00, xadd};
  assign num_z = clip(sum_z);
  assign num_c = clip(sum_c);
  assign num_x = clip(sum_x);

  always_comb begin
    sel_r = SelZero;
    sel_g = SelZero;
    sel_b = SelZero;
    case (front_i.sector)
      3'd0: begin
        sel_r = SelChroma;
        sel_g = SelSecond;
      end
      3'd1: begin
        sel_r = SelSecond;
        sel_g = SelChroma;
      end
      3'd2: begin
        sel_g = SelChroma;
        sel_b = SelSecond;
      end
      3'd3: begin
        sel_g = SelSecond;
        sel_b = SelChroma;
      end
      3'd4: begin
        sel_r = SelSecond;
        sel_b = SelChroma;
      end
      default: begin
        sel_r = SelChroma;
        sel_b = SelSecond;
      end
    endcase
  end

  assign num_r_d = pick(sel_r, num_z, num_c, num_x);
  assign num_g_d = pick(sel_g, num_z, num_c, num_x);
  assign num_b_d = pick(sel_b, num_z, num_c, num_x);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= front_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    alpha_q <= front_i.alpha;
    num_r_q <= num_r_d;
    num_g_q <= num_g_d;
    num_b_q <= num_b_d;
  end

  assign valid_o = valid_q;
  assign alpha_o = alpha_q;
  assign num_r_o = num_r_q;
  assign num_g_o = num_g_q;
  assign num_b_o = num_b_q;

endmodule
`default_nettype wire

// File: src/hslrgb_div.sv
`default_nettype none
module hslrgb_div (
  input  wire logic                          clk_i,
  input  wire logic [hslrgb_pkg::NumW-1:0]   num_i,
  output logic [hslrgb_pkg::ChanW-1:0]       chan_o
);

  localparam int unsigned EstW = hslrgb_pkg::NumW + hslrgb_pkg::RecipW;

  logic [EstW-1:0]              est;
  logic [hslrgb_pkg::QW-1:0]    qa_d, qa_q, qb_q;
  logic [hslrgb_pkg::NumW-1:0]  na_q, nb_q;
  logic [hslrgb_pkg::NumW:0]    prod_d, prod_q, rem;
  logic [hslrgb_pkg::QW:0]      qfix;
  logic [hslrgb_pkg::ChanW-1:0] chan_d, chan_q;

  // Reciprocal estimate, then one correction step on the remainder.
  assign est    = {12'd0, num_i} * {29'd0, hslrgb_pkg::OutRecip};
  assign qa_d   = est[EstW-1:hslrgb_pkg::RecipShift];
  assign prod_d = {21'd0, qa_q} * {9'd0, hslrgb_pkg::OutDiv};
  assign rem    = {1'b0, nb_q} - prod_q;
  assign qfix   = {1'b0, qb_q} + {9'd0, (rem >= {9'd0, hslrgb_pkg::OutDiv})};

  always_comb begin
    if (qfix > 10'd255) begin
      chan_d = '1;
    end else begin
      chan_d = qfix[hslrgb_pkg::ChanW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    qa_q   <= qa_d;
    na_q   <= num_i;
    prod_q <= prod_d;
    qb_q   <= qa_q;
    nb_q   <= na_q;
    chan_q <= chan_d;
  end

  assign chan_o = chan_q;

endmodule
`default_nettype wire

// File: src/hsl_to_rgb_converter_core.sv
// HSL to RGB pixel converter.
// Input: a beat is taken at a rising edge where start is high and busy is low.
// hue_i is in 1/64 degree (values of 23040 and up wrap once); alpha_in_i is
// carried along unchanged. busy is always low, so a beat can enter each cycle.
// Saturation (index 0) and lightness (index 1) are written through cfg_we_i,
// cfg_idx_i and cfg_data_i at any rising edge; other indexes are ignored.
// Both values are sampled when a beat enters, so a write affects only later
// beats.
// Output: result_valid_o is high for one cycle with red_o, green_o, blue_o
// and alpha_out_o; the receiver cannot hold a result off. One result per
// cycle is sustained: three stages form hue sector and chroma terms, one
// forms the scaled channel sums, and three divide each sum by the channel
// step.
// Reset clears all valid bits, so nothing pending is delivered afterward, and
// sets saturation to 204 and lightness to 153.
`default_nettype none
module hsl_to_rgb_converter_core (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [hslrgb_pkg::HueW-1:0]         hue_i,
  input  wire logic [hslrgb_pkg::ChanW-1:0]        alpha_in_i,
  input  wire logic                                cfg_we_i,
  input  wire logic [hslrgb_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire logic [hslrgb_pkg::ChanW-1:0]        cfg_data_i,
  output logic                                     result_valid_o,
  output logic [hslrgb_pkg::ChanW-1:0]             red_o,
  output logic [hslrgb_pkg::ChanW-1:0]             green_o,
  output logic [hslrgb_pkg::ChanW-1:0]             blue_o,
  output logic [hslrgb_pkg::ChanW-1:0]             alpha_out_o
);

  logic [hslrgb_pkg::ChanW-1:0] sat_d, sat_q, light_d, light_q;
  logic                         accept;
  hslrgb_pkg::front_t           front;
  logic                         mix_valid;
  logic [hslrgb_pkg::ChanW-1:0] mix_alpha;
  logic [hslrgb_pkg::NumW-1:0]  num_r, num_g, num_b;
  logic [2:0]                   vd_q;
  logic [hslrgb_pkg::ChanW-1:0] ad0_q, ad1_q, ad2_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    sat_d   = sat_q;
    light_d = light_q;
    if (cfg_we_i) begin
      if (cfg_idx_i == hslrgb_pkg::CfgSaturation) begin
        sat_d = cfg_data_i;
      end else if (cfg_idx_i == hslrgb_pkg::CfgLightness) begin
        light_d = cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_q   <= hslrgb_pkg::SatReset;
      light_q <= hslrgb_pkg::LightReset;
      vd_q    <= '0;
    end else begin
      sat_q   <= sat_d;
      light_q <= light_d;
      vd_q    <= {vd_q[1:0], mix_valid};
    end
  end

  always_ff @(posedge clk_i) begin
    ad0_q <= mix_alpha;
    ad1_q <= ad0_q;
    ad2_q <= ad1_q;
  end

  hslrgb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (accept),
    .hue_i      (hue_i),
    .alpha_i    (alpha_in_i),
    .sat_i      (sat_q),
    .light_i    (light_q),
    .front_o    (front)
  );

  hslrgb_mix u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .front_i (front),
    .valid_o (mix_valid),
    .alpha_o (mix_alpha),
    .num_r_o (num_r),
    .num_g_o (num_g),
    .num_b_o (num_b)
  );

  hslrgb_div u_div_r (
    .clk_i  (clk_i),
    .num_i  (num_r),
    .chan_o (red_o)
  );

  hslrgb_div u_div_g (
    .clk_i  (clk_i),
    .num_i  (num_g),
    .chan_o (green_o)
  );

  hslrgb_div u_div_b (
    .clk_i  (clk_i),
    .num_i  (num_b),
    .chan_o (blue_o)
  );

  assign result_valid_o = vd_q[2];
  assign alpha_out_o    = ad2_q;

endmodule
`default_nettype wire
